// ----- hw/rtl/eau2x_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eau2x_pkg
// Shared types and constants of the edge aware 2x upscaler.
// ----------------------------------------------------------------------------
package eau2x_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned ADDR_W     = $clog2(MAX_WIDTH);
  localparam int unsigned PIX_W      = 32;
  localparam int unsigned COL_W      = 10;
  localparam int unsigned CFG_W      = 11;
  localparam int unsigned W_LIM      = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int unsigned H_LIM      = 1024;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned OUT_BITS   = 4 * PIX_W + 2 * COL_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic  wr_en;
    addr_t wr_addr;
    pix_t  wr_newer;
    pix_t  wr_older;
    addr_t rd_addr0;
    addr_t rd_addr1;
  } ls_req_t;

  typedef struct packed {
    pix_t newer0;
    pix_t newer1;
    pix_t older;
  } ls_rsp_t;

  function automatic addr_t col_to_addr(input logic [COL_W:0] col);
    logic [ADDR_W+COL_W:0] wide;
    wide = (ADDR_W + COL_W + 1)'(col);
    return wide[ADDR_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/eau2x_line_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eau2x_line_store
// Two line memories (row above, row two above) with registered reads and
// write-to-read forwarding for same-cycle accesses to one entry.
// ----------------------------------------------------------------------------
module eau2x_line_store (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  eau2x_pkg::ls_req_t req_i,
  output eau2x_pkg::ls_rsp_t rsp_o
);

  eau2x_pkg::pix_t newer_mem [eau2x_pkg::MAX_WIDTH];
  eau2x_pkg::pix_t older_mem [eau2x_pkg::MAX_WIDTH];

  eau2x_pkg::pix_t newer0_q, newer1_q, older_q;
  eau2x_pkg::pix_t fwd_newer_q, fwd_older_q;
  logic            fwd0_q, fwd1_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      newer_mem[req_i.wr_addr] <= req_i.wr_newer;
      older_mem[req_i.wr_addr] <= req_i.wr_older;
    end
    newer0_q    <= newer_mem[req_i.rd_addr0];
    newer1_q    <= newer_mem[req_i.rd_addr1];
    older_q     <= older_mem[req_i.rd_addr0];
    fwd_newer_q <= req_i.wr_newer;
    fwd_older_q <= req_i.wr_older;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd0_q <= 1'b0;
      fwd1_q <= 1'b0;
    end else begin
      fwd0_q <= req_i.wr_en && (req_i.wr_addr == req_i.rd_addr0);
      fwd1_q <= req_i.wr_en && (req_i.wr_addr == req_i.rd_addr1);
    end
  end

  assign rsp_o.newer0 = fwd0_q ? fwd_newer_q : newer0_q;
  assign rsp_o.newer1 = fwd1_q ? fwd_newer_q : newer1_q;
  assign rsp_o.older  = fwd0_q ? fwd_older_q : older_q;

endmodule

// ----- hw/rtl/edge_aware_2x_upscaler_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_aware_2x_upscaler_core
// Simplified EPX 2x upscaler: raster pixels in, one 2x2 block per source
// pixel out, rows held in two line memories, last row flushed as it streams.
// Blocks are evaluated from the registered pixel and queued before m_axis.
// Throughput: one pixel per cycle while the queue has room; a last-row pixel
// can make two or three blocks, and the four-entry queue holds off s_axis.
// Reset: counters at (0,0), size 640x480; line memories are not cleared.
// ----------------------------------------------------------------------------
module edge_aware_2x_upscaler_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // config write channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [eau2x_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [eau2x_pkg::CFG_W-1:0]           cfg_data_i,
  // pixel input
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [eau2x_pkg::PIX_W-1:0]           s_axis_tdata,  // pixel_word
  // block output
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // top_left, top_right, bottom_left, bottom_right, src_col, src_row, zero pad
  output logic [eau2x_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                  m_axis_tlast   // frame_done
);

  typedef struct packed {
    eau2x_pkg::pix_t              top_left;
    eau2x_pkg::pix_t              top_right;
    eau2x_pkg::pix_t              bottom_left;
    eau2x_pkg::pix_t              bottom_right;
    logic [eau2x_pkg::COL_W-1:0]  src_col;
    logic [eau2x_pkg::COL_W-1:0]  src_row;
    logic                         frame_done;
  } block_t;

  localparam int unsigned PAD_W = eau2x_pkg::OUT_TDATA_W - eau2x_pkg::OUT_BITS;

  function automatic block_t epx(input eau2x_pkg::pix_t p, input eau2x_pkg::pix_t a,
                                 input eau2x_pkg::pix_t b, input eau2x_pkg::pix_t c,
                                 input eau2x_pkg::pix_t d,
                                 input logic [eau2x_pkg::COL_W-1:0] col,
                                 input logic [eau2x_pkg::COL_W-1:0] row,
                                 input logic done);
    block_t blk;
    blk.top_left     = (c == a) ? a : p;
    blk.top_right    = (a == b) ? b : p;
    blk.bottom_left  = (d == c) ? c : p;
    blk.bottom_right = (b == d) ? d : p;
    blk.src_col      = col;
    blk.src_row      = row;
    blk.frame_done   = done;
    return blk;
  endfunction

  // configuration
  logic [eau2x_pkg::CFG_W-1:0] width_q, height_q;
  logic [eau2x_pkg::CFG_W-1:0] eff_w, eff_h;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= eau2x_pkg::CFG_W'(640);
      height_q <= eau2x_pkg::CFG_W'(480);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        eau2x_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        eau2x_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_w = width_q;
    if (width_q == '0) eff_w = eau2x_pkg::CFG_W'(1);
    else if (width_q > eau2x_pkg::CFG_W'(eau2x_pkg::W_LIM)) eff_w = eau2x_pkg::CFG_W'(eau2x_pkg::W_LIM);
    eff_h = height_q;
    if (height_q == '0) eff_h = eau2x_pkg::CFG_W'(1);
    else if (height_q > eau2x_pkg::CFG_W'(eau2x_pkg::H_LIM)) eff_h = eau2x_pkg::CFG_W'(eau2x_pkg::H_LIM);
  end

  // accept stage: position and memory read
  logic [eau2x_pkg::COL_W-1:0] col_q, col_d, row_q, row_d;
  logic [eau2x_pkg::COL_W-1:0] x_a, y_a;
  logic                        restart, in_beat;

  assign in_beat = s_axis_tvalid && s_axis_tready;
  assign restart = ({1'b0, col_q} >= eff_w) || ({1'b0, row_q} >= eff_h);
  assign x_a     = restart ? '0 : col_q;
  assign y_a     = restart ? '0 : row_q;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_beat) begin
      if (({1'b0, x_a} + eau2x_pkg::CFG_W'(1)) < eff_w) begin
        col_d = x_a + eau2x_pkg::COL_W'(1);
        row_d = y_a;
      end else begin
        col_d = '0;
        row_d = (({1'b0, y_a} + eau2x_pkg::CFG_W'(1)) < eff_h) ?
                y_a + eau2x_pkg::COL_W'(1) : '0;
      end
    end
  end

  // compute stage registers
  logic                        vld_b_q;
  logic [eau2x_pkg::COL_W-1:0] x_b_q, y_b_q;
  eau2x_pkg::pix_t             v_b_q;
  eau2x_pkg::pix_t             left0_q, left1_q, left2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      vld_b_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      vld_b_q <= in_beat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      x_b_q <= x_a;
      y_b_q <= y_a;
      v_b_q <= s_axis_tdata;
    end
  end

  eau2x_pkg::ls_req_t ls_req;
  eau2x_pkg::ls_rsp_t ls_rsp;
  eau2x_pkg::pix_t    up_b;

  assign up_b = ls_rsp.newer0;

  always_comb begin
    ls_req.wr_en    = vld_b_q;
    ls_req.wr_addr  = eau2x_pkg::col_to_addr({1'b0, x_b_q});
    ls_req.wr_newer = v_b_q;
    ls_req.wr_older = up_b;
    ls_req.rd_addr0 = eau2x_pkg::col_to_addr({1'b0, x_a});
    ls_req.rd_addr1 = eau2x_pkg::col_to_addr({1'b0, x_a} + eau2x_pkg::CFG_W'(1));
  end

  eau2x_line_store u_line_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ls_req),
    .rsp_o  (ls_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left0_q <= '0;
      left1_q <= '0;
      left2_q <= '0;
    end else if (vld_b_q) begin
      left0_q <= up_b;
      left1_q <= v_b_q;
      left2_q <= left1_q;
    end
  end

  // block evaluation
  logic   last_row, last_col, r1_vld, r2_vld, r3_vld;
  logic   x_gt0, y_eq0;
  block_t blk1, blk2, blk3;
  logic [1:0] n_b;

  assign last_row = ({1'b0, y_b_q} == (eff_h - eau2x_pkg::CFG_W'(1)));
  assign last_col = ({1'b0, x_b_q} == (eff_w - eau2x_pkg::CFG_W'(1)));
  assign x_gt0    = (x_b_q != '0);
  assign y_eq0    = (y_b_q == '0);
  assign r1_vld   = vld_b_q && !y_eq0;
  assign r2_vld   = vld_b_q && last_row && x_gt0;
  assign r3_vld   = vld_b_q && last_row && last_col;
  assign n_b      = 2'(r1_vld) + 2'(r2_vld) + 2'(r3_vld);

  always_comb begin
    // block of the row above at this column
    blk1 = epx(up_b,
               (y_b_q == eau2x_pkg::COL_W'(1)) ? up_b : ls_rsp.older,
               (({1'b0, x_b_q} + eau2x_pkg::CFG_W'(1)) < eff_w) ? ls_rsp.newer1 : up_b,
               x_gt0 ? left0_q : up_b,
               v_b_q, x_b_q, y_b_q - eau2x_pkg::COL_W'(1), 1'b0);
    // last-row block of the column to the left
    blk2 = epx(left1_q,
               y_eq0 ? left1_q : left0_q,
               v_b_q,
               (x_b_q >= eau2x_pkg::COL_W'(2)) ? left2_q : left1_q,
               left1_q, x_b_q - eau2x_pkg::COL_W'(1), y_b_q, 1'b0);
    // final block of the frame
    blk3 = epx(v_b_q,
               y_eq0 ? v_b_q : up_b,
               v_b_q,
               x_gt0 ? left1_q : v_b_q,
               v_b_q, x_b_q, y_b_q, 1'b1);
  end

  // output queue
  block_t                        fifo_q [eau2x_pkg::FIFO_DEPTH];
  logic [eau2x_pkg::FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [eau2x_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [eau2x_pkg::FIFO_AW-1:0] off2, off3;
  logic                          out_beat;
  block_t                        head;

  assign out_beat = m_axis_tvalid && m_axis_tready;
  assign cnt_d    = cnt_q + eau2x_pkg::CNT_W'(n_b) - eau2x_pkg::CNT_W'(out_beat);
  assign s_axis_tready = (cnt_d <= eau2x_pkg::CNT_W'(1));
  assign off2     = eau2x_pkg::FIFO_AW'(r1_vld);
  assign off3     = eau2x_pkg::FIFO_AW'(r1_vld) + eau2x_pkg::FIFO_AW'(r2_vld);

  always_ff @(posedge clk_i) begin
    if (r1_vld) fifo_q[wr_ptr_q] <= blk1;
    if (r2_vld) fifo_q[wr_ptr_q + off2] <= blk2;
    if (r3_vld) fifo_q[wr_ptr_q + off3] <= blk3;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + eau2x_pkg::FIFO_AW'(n_b);
      rd_ptr_q <= rd_ptr_q + eau2x_pkg::FIFO_AW'(out_beat);
      cnt_q    <= cnt_d;
    end
  end

  assign head          = fifo_q[rd_ptr_q];
  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tlast  = head.frame_done;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, head.src_row, head.src_col, head.bottom_right,
                          head.bottom_left, head.top_right, head.top_left};

  // checks
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= eau2x_pkg::CNT_W'(eau2x_pkg::FIFO_DEPTH))
    else $error("output queue overflow");

  a_room_for_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_b_q |-> (cnt_q <= eau2x_pkg::CNT_W'(1)))
    else $error("no room for evaluated blocks");

endmodule
